// ===== rtl/core/ssup_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssup_pkg;

  // Field widths fixed by the stream format
  localparam int CODE_W = 16;
  localparam int CUR_W  = 15;
  localparam int MV_W   = 20;
  localparam int THR_W  = 9;
  localparam int WIN_W  = 16;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 3;

  // Default converter resolution
  localparam int CODE_BITS_DEF = 16;

  // Current scaling: mA = 43 * (4950*code - 2500*FS) / (6*FS)
  localparam int I_GAIN   = 212850;   // 4950 * 43
  localparam int I_GAIN_W = 18;
  localparam int I_OFS_K  = 107500;   // 2500 * 43, times FS
  localparam int I_DEN_K  = 6;        // times FS

  // Voltage scaling: mV = code * 53 / 5
  localparam int V_GAIN   = 53;
  localparam int V_GAIN_W = 6;
  localparam int V_DIV    = 5;

  // Ripple threshold = diff / 200, by reciprocal (exact for 16-bit diff)
  localparam int THR_SHIFT   = 24;
  localparam int THR_RECIP   = (1 << THR_SHIFT) / 200 + 1;
  localparam int THR_RECIP_W = 17;
  localparam int THR_RST     = 10;

  // Register reset values
  localparam int WIN_LEN_RST   = 862;
  localparam int OC_LIMIT_RST  = 17558;
  localparam int VLIM_RST      = 1048575;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_AC_LOW_SET    = 3'd1,
    REG_AC_LOW_CLEAR  = 3'd2,
    REG_OC_LIMIT      = 3'd3,
    REG_HEAVY_LOAD    = 3'd4,
    REG_VLIM_HEAVY    = 3'd5,
    REG_VLIM_LIGHT    = 3'd6,
    REG_VRELEASE      = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssup_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Five-stage conversion pipe: raw codes in, mA and mV out, AC code carried along.
module ssup_conv
  import ssup_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CODE_BITS-1:0] in_ac,
  input  wire logic [CODE_BITS-1:0] in_cur_code,
  input  wire logic [CODE_BITS-1:0] in_vout_code,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CODE_BITS-1:0]      out_ac,
  output logic [CUR_W-1:0]          out_cur,
  output logic [MV_W-1:0]           out_mv
);

  localparam longint unsigned FS    = (64'd1 << CODE_BITS) - 64'd1;
  localparam longint unsigned I_OFS = 64'(I_OFS_K) * FS;
  localparam longint unsigned Y_MAX = 64'(I_GAIN) * FS - I_OFS;
  localparam int              Y_W   = $clog2(Y_MAX + 64'd1);
  localparam longint unsigned I_DEN = 64'(I_DEN_K) * FS;
  localparam longint unsigned I_RCP = (64'd1 << Y_W) / I_DEN;
  localparam int              I_RCP_W = $clog2(I_RCP + 64'd1);
  localparam int              IP_W  = Y_W + I_RCP_W;
  localparam int              P_W   = CODE_BITS + I_GAIN_W;
  localparam int              V_W   = CODE_BITS + V_GAIN_W;
  localparam longint unsigned V_RCP = (64'd1 << V_W) / V_DIV;
  localparam int              V_RCP_W = $clog2(V_RCP + 64'd1);
  localparam int              VP_W  = V_W + V_RCP_W;

  localparam logic [P_W-1:0] I_OFS_P = P_W'(I_OFS);
  localparam logic [Y_W-1:0] I_DEN_Y = Y_W'(I_DEN);
  localparam logic [V_W-1:0] V_DIV_V = V_W'(V_DIV);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // S1: input register
  logic [CODE_BITS-1:0] ac1_r, ic1_r, vc1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ac1_r <= in_ac;
      ic1_r <= in_cur_code;
      vc1_r <= in_vout_code;
    end
  end

  // S2: gain and offset
  logic [CODE_BITS-1:0] ac2_r;
  logic [Y_W-1:0]       y2_r, y_nxt;
  logic [V_W-1:0]       vv2_r;
  logic [P_W-1:0]       i_scaled;

  assign i_scaled = P_W'(ic1_r) * P_W'(I_GAIN);
  assign y_nxt    = (i_scaled > I_OFS_P) ? Y_W'(i_scaled - I_OFS_P) : '0;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ac2_r <= ac1_r;
      y2_r  <= y_nxt;
      vv2_r <= V_W'(vc1_r) * V_W'(V_GAIN);
    end
  end

  // S3: quotient estimates by reciprocal, low by at most one
  logic [CODE_BITS-1:0] ac3_r;
  logic [Y_W-1:0]       y3_r;
  logic [V_W-1:0]       vv3_r;
  logic [CUR_W-1:0]     qi3_r;
  logic [MV_W-1:0]      qv3_r;
  logic [IP_W-1:0]      i_prod;
  logic [VP_W-1:0]      v_prod;

  assign i_prod = IP_W'(y2_r) * IP_W'(I_RCP);
  assign v_prod = VP_W'(vv2_r) * VP_W'(V_RCP);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ac3_r <= ac2_r;
      y3_r  <= y2_r;
      vv3_r <= vv2_r;
      qi3_r <= CUR_W'(i_prod >> Y_W);
      qv3_r <= MV_W'(v_prod >> V_W);
    end
  end

  // S4: back-multiply the estimates
  logic [CODE_BITS-1:0] ac4_r;
  logic [Y_W-1:0]       y4_r, mi4_r;
  logic [V_W-1:0]       vv4_r, mv4_r;
  logic [CUR_W-1:0]     qi4_r;
  logic [MV_W-1:0]      qv4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ac4_r <= ac3_r;
      y4_r  <= y3_r;
      vv4_r <= vv3_r;
      qi4_r <= qi3_r;
      qv4_r <= qv3_r;
      mi4_r <= Y_W'(Y_W'(qi3_r) * I_DEN_Y);
      mv4_r <= V_W'(V_W'(qv3_r) * V_DIV_V);
    end
  end

  // S5: remainder check, bump quotient where it fell short
  logic [CODE_BITS-1:0] ac5_r;
  logic [CUR_W-1:0]     cur5_r;
  logic [MV_W-1:0]      mv5_r;
  logic [Y_W-1:0]       i_rem;
  logic [V_W-1:0]       v_rem;

  assign i_rem = y4_r - mi4_r;
  assign v_rem = vv4_r - mv4_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ac5_r  <= ac4_r;
      cur5_r <= (i_rem >= I_DEN_Y) ? qi4_r + CUR_W'(1) : qi4_r;
      mv5_r  <= (v_rem >= V_DIV_V) ? qv4_r + MV_W'(1) : qv4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_ac    = ac5_r;
  assign out_cur   = cur5_r;
  assign out_mv    = mv5_r;

endmodule

`default_nettype wire

// ===== rtl/core/supply_sample_supervisor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Supply sample supervisor.
// One item on in_* is one sample period: AC, current and output-voltage codes.
// One item leaves on out_* for every item taken in, in the same order, with
// the converted current and voltage, the latched AC window extremes and
// ripple threshold, and the three alarm flags. out_tlast marks the sample
// that closed an AC min/max window.
// The cfg_* port writes one register per cycle with cfg_we high; write it
// only while no items are in flight.
// From in_* acceptance to out_tvalid an item passes five stages of
// conversion (input register, gain, reciprocal multiply, back-multiply,
// remainder correction), one stage that updates the window and alarm state,
// and one output register that forms the ripple threshold.
// Throughput is one item per cycle while out_tready stays high.
// Reset clears the pipe, loads the register defaults (window of 862 samples)
// and sets the latched threshold to 10 until the first window closes.
// When the receiver stalls, items keep being taken until all seven stages
// hold one; in_tready then follows out_tready.
module supply_sample_supervisor
  import ssup_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: ac_code[15:0], current_code[31:16], vout_code[47:32]
  input  wire logic [47:0]          in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // out_tdata: ac_window_max[15:0], ac_window_min[31:16],
  // ac_ripple_threshold[40:32], current_ma[55:41], vout_mv[75:56],
  // low_ac_alarm[76], overcurrent_alarm[77], voltage_limited[78], zero[79]
  output logic [79:0]               out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic                      out_tlast,    // window_done
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'((64'd1 << CODE_BITS) - 64'd1);
  localparam int THP_W = CODE_W + THR_RECIP_W;

  // Configuration registers
  logic [WIN_W-1:0] win_len_r;
  logic [CODE_W-1:0] ac_set_r, ac_clr_r;
  logic [CUR_W-1:0] oc_lim_r, heavy_r;
  logic [MV_W-1:0]  vlim_heavy_r, vlim_light_r, vrel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r    <= WIN_W'(WIN_LEN_RST);
      ac_set_r     <= '0;
      ac_clr_r     <= '0;
      oc_lim_r     <= CUR_W'(OC_LIMIT_RST);
      heavy_r      <= '0;
      vlim_heavy_r <= MV_W'(VLIM_RST);
      vlim_light_r <= MV_W'(VLIM_RST);
      vrel_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: win_len_r    <= cfg_wdata[WIN_W-1:0];
        REG_AC_LOW_SET:    ac_set_r     <= cfg_wdata[CODE_W-1:0];
        REG_AC_LOW_CLEAR:  ac_clr_r     <= cfg_wdata[CODE_W-1:0];
        REG_OC_LIMIT:      oc_lim_r     <= cfg_wdata[CUR_W-1:0];
        REG_HEAVY_LOAD:    heavy_r      <= cfg_wdata[CUR_W-1:0];
        REG_VLIM_HEAVY:    vlim_heavy_r <= cfg_wdata[MV_W-1:0];
        REG_VLIM_LIGHT:    vlim_light_r <= cfg_wdata[MV_W-1:0];
        REG_VRELEASE:      vrel_r       <= cfg_wdata[MV_W-1:0];
      endcase
    end
  end

  // Conversion pipe
  logic                 c_valid, c_ready;
  logic [CODE_BITS-1:0] c_ac;
  logic [CUR_W-1:0]     c_cur;
  logic [MV_W-1:0]      c_mv;

  ssup_conv #(
    .CODE_BITS (CODE_BITS)
  ) u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_ac        (in_tdata[CODE_BITS-1:0]),
    .in_cur_code  (in_tdata[16 +: CODE_BITS]),
    .in_vout_code (in_tdata[32 +: CODE_BITS]),
    .out_valid    (c_valid),
    .out_ready    (c_ready),
    .out_ac       (c_ac),
    .out_cur      (c_cur),
    .out_mv       (c_mv)
  );

  // Handshake of the state stage and the output register
  logic v6_r, out_valid_r;
  logic rdy6, rdy7, acc6;

  assign rdy7    = !out_valid_r || out_tready;
  assign rdy6    = !v6_r || rdy7;
  assign c_ready = rdy6;
  assign acc6    = c_valid && rdy6;

  // Window and alarm state; its registers double as the stage payload
  logic [WIN_W-1:0]  win_cnt_r, win_cnt_dec;
  logic [CODE_W-1:0] rmax_r, rmin_r, lmax_r, lmin_r, diff_r;
  logic [CODE_W-1:0] ac_ext, rmax_upd, rmin_upd, lmin_clamp, lmax_nxt;
  logic              seen_r, low_r, oc_r, lim_r;
  logic              win_close, low_nxt, lim_nxt;
  logic [MV_W-1:0]   trip;
  logic [CUR_W-1:0]  cur6_r;
  logic [MV_W-1:0]   mv6_r;
  logic              done6_r;

  assign ac_ext      = CODE_W'(c_ac);
  assign rmax_upd    = (ac_ext > rmax_r) ? ac_ext : rmax_r;
  assign rmin_upd    = (ac_ext < rmin_r) ? ac_ext : rmin_r;
  assign lmin_clamp  = (rmin_upd > rmax_upd) ? rmax_upd : rmin_upd;
  assign win_cnt_dec = win_cnt_r - WIN_W'(1);
  assign win_close   = (win_cnt_dec == '0);
  assign lmax_nxt    = win_close ? rmax_upd : lmax_r;
  assign trip        = (c_cur > heavy_r) ? vlim_heavy_r : vlim_light_r;

  // low-AC hysteresis: set test wins over clear test
  always_comb begin
    priority if (lmax_nxt < ac_set_r) begin
      low_nxt = 1'b1;
    end else if (lmax_nxt > ac_clr_r) begin
      low_nxt = 1'b0;
    end else begin
      low_nxt = low_r;
    end
  end

  // overvoltage limit: release below the release level, trip at the load level
  always_comb begin
    if (lim_r) begin
      lim_nxt = !(c_mv < vrel_r);
    end else begin
      lim_nxt = (c_mv >= trip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r      <= 1'b0;
      win_cnt_r <= WIN_W'(WIN_LEN_RST);
      rmax_r    <= '0;
      rmin_r    <= CODE_MAX;
      lmax_r    <= '0;
      lmin_r    <= '0;
      diff_r    <= '0;
      seen_r    <= 1'b0;
      low_r     <= 1'b0;
      oc_r      <= 1'b0;
      lim_r     <= 1'b0;
    end else begin
      if (rdy6) v6_r <= c_valid;
      if (acc6) begin
        if (win_close) begin
          lmax_r    <= rmax_upd;
          lmin_r    <= lmin_clamp;
          diff_r    <= rmax_upd - lmin_clamp;
          seen_r    <= 1'b1;
          rmax_r    <= '0;
          rmin_r    <= CODE_MAX;
          win_cnt_r <= win_len_r;
        end else begin
          rmax_r    <= rmax_upd;
          rmin_r    <= rmin_upd;
          win_cnt_r <= win_cnt_dec;
        end
        low_r <= low_nxt;
        oc_r  <= oc_r || (c_cur > oc_lim_r);
        lim_r <= lim_nxt;
      end
    end
  end

  // per-item fields that are not state
  always_ff @(posedge clk) begin
    if (acc6) begin
      cur6_r  <= c_cur;
      mv6_r   <= c_mv;
      done6_r <= win_close;
    end
  end

  // Output register; ripple threshold by reciprocal multiply
  logic [THP_W-1:0]  thr_prod;
  logic [THR_W-1:0]  thr_nxt;
  logic [CODE_W-1:0] omax_r, omin_r;
  logic [THR_W-1:0]  othr_r;
  logic [CUR_W-1:0]  ocur_r;
  logic [MV_W-1:0]   omv_r;
  logic              olow_r, ooc_r, olim_r, odone_r;

  assign thr_prod = THP_W'(diff_r) * THP_W'(THR_RECIP);
  assign thr_nxt  = seen_r ? THR_W'(thr_prod >> THR_SHIFT) : THR_W'(THR_RST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy7) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && v6_r) begin
      omax_r  <= lmax_r;
      omin_r  <= lmin_r;
      othr_r  <= thr_nxt;
      ocur_r  <= cur6_r;
      omv_r   <= mv6_r;
      olow_r  <= low_r;
      ooc_r   <= oc_r;
      olim_r  <= lim_r;
      odone_r <= done6_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = odone_r;
  assign out_tdata  = {1'b0, olim_r, ooc_r, olow_r, omv_r, ocur_r, othr_r, omin_r, omax_r};

  // Checks
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (omin_r <= omax_r))
    else $error("latched AC minimum above maximum");

  a_oc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r |=> oc_r)
    else $error("overcurrent alarm cleared");

  a_window_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc6 && win_cnt_r == WIN_W'(1)) |=> (v6_r && done6_r))
    else $error("window end not flagged");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !v6_r) |-> c_ready)
    else $error("state stage refused item with empty output");

endmodule

`default_nettype wire
